[rtl/ssf_pkg.sv]
// shared constants and types for the surface shading and fog pipeline
package ssf_pkg;

    // stream and config port widths
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 8;
    localparam int COLOR_W     = 24;

    typedef logic [7:0] t_chan;
    typedef logic [COLOR_W-1:0] t_color;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_SKY_COLOR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_COLOR = 8'd1;

    localparam t_color SKY_RESET = 24'h12141A;
    localparam t_color FOG_RESET = 24'h1C1E26;

    // q14 shading constants
    localparam logic [14:0] Q_ONE        = 15'd16384;
    localparam logic [14:0] K_AMBIENT    = 15'd5734;
    localparam logic [13:0] K_DIFFUSE    = 14'd10650;
    localparam logic [15:0] K_FACE_LIMIT = 16'd11468;
    localparam logic [14:0] K_SIDE_DIM   = 15'd13435;

    // q8.8 fog range, span is 7680 so f = (d - near) * 32 / 15
    localparam logic [13:0] K_FOG_NEAR = 14'd1024;
    localparam logic [13:0] K_FOG_FAR  = 14'd8704;
    localparam int          RECIP_SHIFT = 22;
    localparam logic [18:0] RECIP15    = 19'd279620;  // floor(2^22 / 15)
    localparam logic [4:0]  DIV15      = 5'd15;

    localparam logic [15:0] DEPTH_MISS = 16'hFFFF;

endpackage

[rtl/surface_shade_with_distance_fog.sv]
// lambert shading with quadratic distance fog, one pixel per clock while the output is not stalled
//
// usage:
//   s_axis carries one ray-cast result per transfer: tuser[0] is the hit
//   flag, tdata the base color, surface normal, view ray and q8.8 distance.
//   m_axis returns one shaded pixel per input transfer, in order: rgb and
//   a q8.8 depth code (all ones for a miss, where the sky color is given).
//   the cfg channel writes sky_color (index 0) and fog_color (index 1);
//   other indexes are dropped. cfg_ready is always high, and writes are
//   expected only while no pixel is in flight.
// timing:
//   seven register stages from an s_axis transfer to m_axis_tvalid. one
//   pixel enters every cycle while m_axis_tready does not stall the output;
//   the rate is set by the seven-stage multiply pipeline (dot product, fog
//   reciprocal, light, gain, channel scale, blend, clamp).
// reset:
//   synchronous active-low reset clears all stage valid bits and loads the
//   default sky and fog colors.
// stall:
//   each stage moves when it is empty or the next one moves, so bubbles
//   close up while m_axis_tready is low; s_axis_tready drops only once
//   every stage holds a pixel. nothing is dropped or repeated.
module surface_shade_with_distance_fog (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ssf_pkg::COLOR_W-1:0]         i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // base_r[7:0] base_g[15:8] base_b[23:16] normal_x[39:24] normal_y[55:40]
    // normal_z[71:56] ray_x[87:72] ray_y[103:88] ray_z[119:104]
    // distance[133:120] zero[135:134]
    input  logic [ssf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // hit[0]
    input  logic [0:0]                          s_axis_tuser,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_r[7:0] out_g[15:8] out_b[23:16] depth[39:24]
    output logic [ssf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import ssf_pkg::*;

    // ---------------------------------------------------------------
    // config registers
    // ---------------------------------------------------------------
    t_color r_sky;
    t_color r_fog;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sky <= SKY_RESET;
            r_fog <= FOG_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SKY_COLOR) begin
                r_sky <= i_cfg_data;
            end else if (i_cfg_index == CFG_FOG_COLOR) begin
                r_fog <= i_cfg_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage valid bits and per-stage enables
    // ---------------------------------------------------------------
    logic [7:1] r_v;
    logic [7:1] en;

    // a stage loads when it is empty or its contents move on
    assign en[7] = !r_v[7] || m_axis_tready;
    assign en[6] = !r_v[6] || en[7];
    assign en[5] = !r_v[5] || en[6];
    assign en[4] = !r_v[4] || en[5];
    assign en[3] = !r_v[3] || en[4];
    assign en[2] = !r_v[2] || en[3];
    assign en[1] = !r_v[1] || en[2];

    assign s_axis_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= s_axis_tvalid;
            for (int k = 2; k <= 7; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // input unpack
    // ---------------------------------------------------------------
    t_chan              in_base [3];
    logic signed [15:0] in_nx, in_ny, in_nz, in_rx, in_ry, in_rz;
    logic [13:0]        in_dist;

    assign in_base[0] = s_axis_tdata[7:0];
    assign in_base[1] = s_axis_tdata[15:8];
    assign in_base[2] = s_axis_tdata[23:16];
    assign in_nx      = s_axis_tdata[39:24];
    assign in_ny      = s_axis_tdata[55:40];
    assign in_nz      = s_axis_tdata[71:56];
    assign in_rx      = s_axis_tdata[87:72];
    assign in_ry      = s_axis_tdata[103:88];
    assign in_rz      = s_axis_tdata[119:104];
    assign in_dist    = s_axis_tdata[133:120];

    // ---------------------------------------------------------------
    // stage 1: component products, fog range test, facing test
    // ---------------------------------------------------------------
    logic signed [31:0] r1_px, r1_py, r1_pz;
    logic               r1_near, r1_far;
    logic [17:0]        r1_fx;
    logic               r1_steep;
    logic               r1_hit;
    t_chan              r1_base [3];
    logic [13:0]        r1_dist;

    logic signed [31:0] n1_px, n1_py, n1_pz;
    logic [13:0]        n1_doff;
    logic [15:0]        n1_any;

    always_comb begin
        n1_px   = in_nx * in_rx;
        n1_py   = in_ny * in_ry;
        n1_pz   = in_nz * in_rz;
        n1_doff = in_dist - K_FOG_NEAR;
        // magnitude of ny, -32768 comes out as 32768
        n1_any  = in_ny[15] ? (16'd0 - in_ny) : in_ny;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_px    <= n1_px;
            r1_py    <= n1_py;
            r1_pz    <= n1_pz;
            r1_near  <= (in_dist <= K_FOG_NEAR);
            r1_far   <= (in_dist >= K_FOG_FAR);
            r1_fx    <= {n1_doff[12:0], 5'b0};
            r1_steep <= (n1_any > K_FACE_LIMIT);
            r1_hit   <= s_axis_tuser[0];
            r1_base  <= in_base;
            r1_dist  <= in_dist;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: dot sum, magnitude, saturate; fog reciprocal product
    // ---------------------------------------------------------------
    logic [14:0]        r2_nd;
    logic [36:0]        r2_fprod;
    logic [17:0]        r2_fx;
    logic               r2_near, r2_far, r2_steep, r2_hit;
    t_chan              r2_base [3];
    logic [13:0]        r2_dist;

    logic signed [33:0] n2_dot;
    logic [33:0]        n2_mag;
    logic [18:0]        n2_ndraw;
    logic [14:0]        n2_nd;

    always_comb begin
        n2_dot   = 34'(r1_px) + 34'(r1_py) + 34'(r1_pz);
        n2_mag   = n2_dot[33] ? (34'd0 - n2_dot) : n2_dot;
        n2_ndraw = n2_mag[32:14];
        n2_nd    = (n2_ndraw > 19'(Q_ONE)) ? Q_ONE : n2_ndraw[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_nd    <= n2_nd;
            r2_fprod <= r1_fx * RECIP15;
            r2_fx    <= r1_fx;
            r2_near  <= r1_near;
            r2_far   <= r1_far;
            r2_steep <= r1_steep;
            r2_hit   <= r1_hit;
            r2_base  <= r1_base;
            r2_dist  <= r1_dist;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: diffuse light; fog quotient with one-step correction
    // ---------------------------------------------------------------
    logic [14:0]        r3_light;
    logic [14:0]        r3_f;
    logic               r3_steep, r3_hit;
    t_chan              r3_base [3];
    logic [13:0]        r3_dist;

    logic [28:0]        n3_diff;
    logic [14:0]        n3_q0;
    logic [19:0]        n3_rem;
    logic [14:0]        n3_q;
    logic [14:0]        n3_f;

    always_comb begin
        n3_diff = K_DIFFUSE * r2_nd;
        n3_q0   = r2_fprod[RECIP_SHIFT+14:RECIP_SHIFT];
        // remainder against the truncated quotient, at most one short
        n3_rem  = 20'(r2_fx) - (20'(n3_q0) * 20'(DIV15));
        n3_q    = (n3_rem >= 20'(DIV15)) ? (n3_q0 + 15'd1) : n3_q0;
        if (r2_near) begin
            n3_f = '0;
        end else if (r2_far) begin
            n3_f = Q_ONE;
        end else begin
            n3_f = n3_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_light <= K_AMBIENT + n3_diff[28:14];
            r3_f     <= n3_f;
            r3_steep <= r2_steep;
            r3_hit   <= r2_hit;
            r3_base  <= r2_base;
            r3_dist  <= r2_dist;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: gain with side dimming; fog weight f squared
    // ---------------------------------------------------------------
    logic [14:0]        r4_gain;
    logic [14:0]        r4_t;
    logic               r4_hit;
    t_chan              r4_base [3];
    logic [13:0]        r4_dist;

    logic [29:0]        n4_gain;
    logic [29:0]        n4_t;

    always_comb begin
        n4_gain = r3_light * (r3_steep ? Q_ONE : K_SIDE_DIM);
        n4_t    = r3_f * r3_f;
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_gain <= n4_gain[28:14];
            r4_t    <= n4_t[28:14];
            r4_hit  <= r3_hit;
            r4_base <= r3_base;
            r4_dist <= r3_dist;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: lit channels
    // ---------------------------------------------------------------
    t_chan              r5_lit [3];
    logic [14:0]        r5_t;
    logic               r5_hit;
    logic [13:0]        r5_dist;

    logic [22:0]        n5_prod [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n5_prod[c] = r4_base[c] * r4_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int c = 0; c < 3; c++) begin
                r5_lit[c] <= n5_prod[c][21:14];
            end
            r5_t    <= r4_t;
            r5_hit  <= r4_hit;
            r5_dist <= r4_dist;
        end
    end

    // ---------------------------------------------------------------
    // stage 6: blend toward fog color
    // ---------------------------------------------------------------
    logic signed [24:0] r6_acc [3];
    logic               r6_hit;
    logic [13:0]        r6_dist;

    t_chan              n6_fog  [3];
    logic signed [8:0]  n6_del  [3];
    logic signed [24:0] n6_prod [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n6_fog[c]  = r_fog[(2-c)*8 +: 8];
            n6_del[c]  = $signed({1'b0, n6_fog[c]}) - $signed({1'b0, r5_lit[c]});
            n6_prod[c] = n6_del[c] * $signed({1'b0, r5_t});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int c = 0; c < 3; c++) begin
                r6_acc[c] <= $signed({3'b0, r5_lit[c], 14'b0}) + n6_prod[c];
            end
            r6_hit  <= r5_hit;
            r6_dist <= r5_dist;
        end
    end

    // ---------------------------------------------------------------
    // stage 7: clamp, miss select, output register
    // ---------------------------------------------------------------
    t_chan              r7_rgb [3];
    logic [15:0]        r7_depth;

    t_chan              n7_rgb [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (!r6_hit) begin
                n7_rgb[c] = r_sky[(2-c)*8 +: 8];
            end else if (r6_acc[c][24]) begin
                n7_rgb[c] = '0;
            end else if (r6_acc[c][23:22] != 2'b00) begin
                n7_rgb[c] = 8'hFF;
            end else begin
                n7_rgb[c] = r6_acc[c][21:14];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_rgb   <= n7_rgb;
            r7_depth <= r6_hit ? {2'b00, r6_dist} : DEPTH_MISS;
        end
    end

    assign m_axis_tvalid = r_v[7];
    assign m_axis_tdata  = {r7_depth, r7_rgb[2], r7_rgb[1], r7_rgb[0]};

endmodule

[rtl/ssf_checker.sv]
// port-level checks for the shading pipeline, bound to the top level
module ssf_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ssf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import ssf_pkg::*;

    // reset empties every stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result stays and holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // depth is either the miss code or a 14-bit distance
    a_depth_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:24] == DEPTH_MISS)
                       || (m_axis_tdata[39:38] == 2'b00))
        else $error("bad depth code");

    // input is refused only while the output side is stalled
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without output stall");

endmodule

bind surface_shade_with_distance_fog ssf_checker u_ssf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
